/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL of the clustering coefficient block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LCC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define LCC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define LCC_ASSERT(lbl, clk, rst_n, prop)
`define LCC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/lcc_pkg.sv */
// Package with types, constants and helper functions of the clustering coefficient block.
`default_nettype none
package lcc_pkg;
	localparam int NODES = 64;
	localparam int IDX_W = $clog2(NODES);
	localparam int CNT_W = $clog2(NODES + 1);
	localparam int TRI_W = 11;
	localparam int COEF_W = 17;
	localparam int FRAC_W = 16;
	localparam int NUM_W = TRI_W + FRAC_W + 1;
	localparam int DEN_W = 12;
	localparam logic [COEF_W-1:0] ONE_FIX = COEF_W'(1 << FRAC_W);

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_COMPUTE = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	function automatic logic [CNT_W-1:0] popcount(input logic [NODES-1:0] x);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < NODES; i++) c = c + CNT_W'(x[i]);
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] lowest_bit(input logic [NODES-1:0] x);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = NODES - 1; i >= 0; i--) if (x[i]) r = IDX_W'(i);
		return r;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/lcc_if.sv */
// Channel interfaces for commands into and rows out of the clustering coefficient block.
`default_nettype none
interface lcc_cmd_if import lcc_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [IDX_W-1:0] src_node;
	logic [IDX_W-1:0] dst_node;
	modport source (output valid, action, src_node, dst_node, input ready);
	modport sink (input valid, action, src_node, dst_node, output ready);
endinterface

interface lcc_row_if import lcc_pkg::*; ();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] node_index;
	logic [COEF_W-1:0] coefficient;
	logic [TRI_W-1:0] tri_count;
	logic [IDX_W-1:0] node_degree;
	logic last_row;
	modport source (output valid, node_index, coefficient, tri_count, node_degree,
		last_row, input ready);
	modport sink (input valid, node_index, coefficient, tri_count, node_degree,
		last_row, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lcc_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lcc_div import lcc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);
	localparam int STEP_W = $clog2(NUM_W);

	logic busy_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W:0] rem_sh;
	logic fits;
	logic done_q;

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule
`default_nettype wire

/* hw/rtl/local_clustering_coefficient.sv */
// Top level of the local clustering coefficient block.
// Loads undirected edges into a 64 x 64 adjacency bit memory and, on a compute
// transaction, walks every present node in ascending order and emits one row with
// its degree, triangle count and 2T/(k(k-1)) in 1.16 fixed point (65536 = 1.0).
// An add-edge transaction passes through the accept cycle, one read of both end
// rows, then one write per row through the single write port. Clear needs no
// clearing pass, as the row valid bits are dropped at once. Compute visits each
// present node with a row read and the degree count; for nodes of degree two or
// more it then does one memory read and a masked popcount per neighbor, the final
// neighbor check and a divide; then the row goes out, after any wait on the row
// channel. Command ready is high only between commands.
`default_nettype none
`include "assert_macros.svh"
module local_clustering_coefficient import lcc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	lcc_cmd_if.sink cmd,
	lcc_row_if.source row
);
	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_ADD_RD  = 10'b0000000010,
		S_ADD_WA  = 10'b0000000100,
		S_ADD_WB  = 10'b0000001000,
		S_CMP_ROW = 10'b0000010000,
		S_CMP_K   = 10'b0000100000,
		S_CMP_NB  = 10'b0001000000,
		S_CMP_ACC = 10'b0010000000,
		S_DIV     = 10'b0100000000,
		S_OUT     = 10'b1000000000
	} state_t;

	state_t state_q;
	logic cmd_fire;
	logic [NODES-1:0] present_q;
	logic [NODES-1:0] vld_q;
	logic [NODES-1:0] adj_mem [NODES];

	// Memory ports
	logic [IDX_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
	logic [NODES-1:0] wr_data;
	logic wr_en;
	logic [NODES-1:0] rd_a_q, rd_b_q;
	logic rd_vld_a_q, rd_vld_b_q;
	logic [NODES-1:0] row_a, row_b;

	// Working registers
	logic [IDX_W-1:0] a_q, b_q, v_q, nb;
	logic [NODES-1:0] rest_q, next_mask;
	logic [IDX_W-1:0] k_q;
	logic [CNT_W-1:0] k_new;
	logic [DEN_W-1:0] pairs_q;
	logic [TRI_W-1:0] t_q;
	logic [COEF_W-1:0] coef_q;
	logic ov_q;
	logic out_free;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Output row bounds for the checks at the end
	logic out_has_pairs;
	logic [DEN_W-1:0] out_tri2;
	logic [DEN_W-1:0] out_pairs;

	assign cmd.ready = state_q == S_IDLE;
	assign cmd_fire = cmd.valid && cmd.ready;
	assign out_free = !ov_q || row.ready;
	assign row_a = rd_vld_a_q ? rd_a_q : '0;
	assign row_b = rd_vld_b_q ? rd_b_q : '0;
	assign k_new = popcount(row_a);
	assign nb = lowest_bit(rest_q);
	// Present nodes strictly above the current one; empty means this row is last.
	assign next_mask = present_q & ~((NODES'(2) << v_q) - NODES'(1));

	// Choose read addresses: both end rows on an add, the neighbor row in the walk, the walked row otherwise.
	always_comb begin
		rd_addr_a = v_q;
		rd_addr_b = cmd.dst_node;
		wr_en = 1'b0;
		wr_addr = a_q;
		wr_data = row_a | (NODES'(1) << b_q);
		unique case (state_q)
			S_IDLE: rd_addr_a = cmd.src_node;
			S_ADD_RD: begin
				rd_addr_a = a_q;
				rd_addr_b = b_q;
			end
			S_CMP_NB: rd_addr_a = nb;
			S_ADD_WA: wr_en = a_q != b_q;
			S_ADD_WB: begin
				wr_en = a_q != b_q;
				wr_addr = b_q;
				wr_data = rest_q | (NODES'(1) << a_q);
			end
			default: ;
		endcase
	end

	// Adjacency memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) adj_mem[wr_addr] <= wr_data;
		rd_a_q <= adj_mem[rd_addr_a];
		rd_b_q <= adj_mem[rd_addr_b];
	end

	// Row valid bits stand in for a zeroed memory after reset and clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_a_q <= 1'b0;
			rd_vld_b_q <= 1'b0;
		end else begin
			rd_vld_a_q <= vld_q[rd_addr_a];
			rd_vld_b_q <= vld_q[rd_addr_b];
			if (cmd_fire && cmd.action == ACT_CLEAR) vld_q <= '0;
			else if (wr_en) vld_q[wr_addr] <= 1'b1;
		end
	end

	assign div_req.start = state_q == S_CMP_NB && rest_q == '0;
	assign div_req.num = {t_q, {(FRAC_W + 1){1'b0}}};
	assign div_req.den = pairs_q;

	lcc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			present_q <= '0;
			ov_q <= 1'b0;
		end else begin
			// Hold the row until taken; a new row is loaded only when the slot frees.
			if (state_q == S_OUT && out_free) ov_q <= 1'b1;
			else if (row.valid && row.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd_fire) begin
					priority case (cmd.action)
						ACT_ADD: begin
							present_q <= present_q | (NODES'(1) << cmd.src_node)
								| (NODES'(1) << cmd.dst_node);
							state_q <= S_ADD_RD;
						end
						ACT_COMPUTE: if (present_q != '0) state_q <= S_CMP_ROW;
						ACT_CLEAR: present_q <= '0;
						default: ;
					endcase
				end
				S_ADD_RD: state_q <= S_ADD_WA;
				S_ADD_WA: state_q <= S_ADD_WB;
				S_ADD_WB: state_q <= S_IDLE;
				S_CMP_ROW: state_q <= S_CMP_K;
				S_CMP_K: state_q <= (k_new < CNT_W'(2)) ? S_OUT : S_CMP_NB;
				S_CMP_NB: state_q <= (rest_q == '0) ? S_DIV : S_CMP_ACC;
				S_CMP_ACC: state_q <= S_CMP_NB;
				S_DIV: if (div_rsp.done) state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= (next_mask == '0) ? S_IDLE : S_CMP_ROW;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				a_q <= cmd.src_node;
				b_q <= cmd.dst_node;
				v_q <= lowest_bit(present_q);
			end
			S_ADD_WA: rest_q <= row_b;
			S_CMP_K: begin
				k_q <= k_new[IDX_W-1:0];
				rest_q <= row_a;
				t_q <= '0;
				coef_q <= '0;
				pairs_q <= DEN_W'(k_new) * (DEN_W'(k_new) - DEN_W'(1));
			end
			S_CMP_NB: if (rest_q != '0) rest_q <= rest_q & ~(NODES'(1) << nb);
			S_CMP_ACC: t_q <= t_q + TRI_W'(popcount(row_a & rest_q));
			S_DIV: if (div_rsp.done)
				coef_q <= (div_rsp.quot > NUM_W'(ONE_FIX)) ? ONE_FIX
					: div_rsp.quot[COEF_W-1:0];
			S_OUT: if (out_free) begin
				row.node_index <= v_q;
				row.coefficient <= coef_q;
				row.tri_count <= t_q;
				row.node_degree <= k_q;
				row.last_row <= next_mask == '0;
				v_q <= lowest_bit(next_mask);
			end
			default: ;
		endcase
	end

	assign row.valid = ov_q;

	assign out_has_pairs = row.valid && row.node_degree > IDX_W'(1);
	assign out_tri2 = {row.tri_count, 1'b0};
	assign out_pairs = DEN_W'(row.node_degree) * (DEN_W'(row.node_degree) - DEN_W'(1));

	`LCC_ASSERT(a_div_den, clk, arst_n, div_req.start |-> pairs_q >= DEN_W'(2))
	`LCC_ASSERT(a_row_written, clk, arst_n, (state_q == S_ADD_WA && a_q != b_q) |=> vld_q[a_q])
	`LCC_ASSERT_NEVER(a_coef_range, clk, arst_n, row.valid && row.coefficient > ONE_FIX)
	`LCC_ASSERT(a_tri_bound, clk, arst_n, out_has_pairs |-> out_tri2 <= out_pairs)
endmodule
`default_nettype wire

/* tb/lcc_tb_if.sv */
// Testbench-side notes: channel interfaces come from the RTL; this file holds the row record type.
`default_nettype none
package lcc_tb_pkg;
	import lcc_pkg::*;
	typedef struct {
		logic [IDX_W-1:0] node_index;
		logic [COEF_W-1:0] coefficient;
		logic [TRI_W-1:0] tri_count;
		logic [IDX_W-1:0] node_degree;
		logic last_row;
	} lcc_row_t;
endpackage
`default_nettype wire

/* tb/tb.sv */
// Testbench top for the local clustering coefficient block: graph predictor, drivers and row checks.
`default_nettype none
module tb;
	import lcc_pkg::*;
	import lcc_tb_pkg::*;

	// Scoreboard: mirrors the adjacency store and queues the rows each compute should emit.
	class lcc_scoreboard;
		logic [NODES-1:0] adj [NODES];
		logic [NODES-1:0] present;
		lcc_row_t pending_rows [$];
		int errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			for (int i = 0; i < NODES; i++) adj[i] = '0;
			present = '0;
		endfunction

		function int ones(logic [NODES-1:0] x);
			int c;
			c = 0;
			for (int i = 0; i < NODES; i++) c += x[i];
			return c;
		endfunction

		function void note_command(action_t act, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
			lcc_row_t r;
			int k, t, last_idx;
			longint unsigned q;
			logic [NODES-1:0] rest;
			case (act)
				ACT_ADD: begin
					present[a] = 1'b1;
					present[b] = 1'b1;
					if (a != b) begin
						adj[a][b] = 1'b1;
						adj[b][a] = 1'b1;
					end
				end
				ACT_CLEAR: wipe();
				ACT_COMPUTE: begin
					last_idx = -1;
					for (int v = 0; v < NODES; v++) if (present[v]) last_idx = v;
					for (int v = 0; v < NODES; v++) begin
						if (!present[v]) continue;
						k = ones(adj[v]);
						t = 0;
						q = 0;
						if (k >= 2) begin
							rest = adj[v];
							for (int n = 0; n < NODES; n++) begin
								if (!rest[n]) continue;
								rest[n] = 1'b0;
								t += ones(adj[n] & rest);
							end
							q = (64'd2 * t * 64'd65536) / (k * (k - 1));
							if (q > 65536) q = 65536;
						end
						r.node_index = IDX_W'(v);
						r.coefficient = COEF_W'(q);
						r.tri_count = TRI_W'(t);
						r.node_degree = IDX_W'(k);
						r.last_row = (v == last_idx);
						pending_rows.insert(pending_rows.size(), r);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_row(lcc_row_t got);
			lcc_row_t w;
			if (pending_rows.size() == 0) begin
				$error("unexpected row for node %0d", got.node_index);
				errors++;
				return;
			end
			w = pending_rows.pop_front();
			if (got.node_index !== w.node_index) begin
				$error("node_index exp %0d got %0d", w.node_index, got.node_index);
				errors++;
			end
			if (got.coefficient !== w.coefficient) begin
				$error("coefficient exp %0d got %0d", w.coefficient, got.coefficient);
				errors++;
			end
			if (got.tri_count !== w.tri_count) begin
				$error("tri_count exp %0d got %0d", w.tri_count, got.tri_count);
				errors++;
			end
			if (got.node_degree !== w.node_degree) begin
				$error("node_degree exp %0d got %0d", w.node_degree, got.node_degree);
				errors++;
			end
			if (got.last_row !== w.last_row) begin
				$error("last_row exp %0d got %0d", w.last_row, got.last_row);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	lcc_cmd_if cmd ();
	lcc_row_if row ();

	local_clustering_coefficient i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.row(row.source)
	);

	lcc_scoreboard sb;
	int send_idle_pct;    // percent of cycles the command side holds off
	int stall_pct;        // percent of cycles the row side stalls
	int hold_off_cycles;  // long row stall requested by the stimulus
	int cycle_count;
	int commands_sent;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Abort the run at a generous cycle limit; a compute over many nodes runs long.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Row side: stall at random, or hold off for a long stretch when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row.ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			row.ready <= 1'b0;
		end else begin
			row.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every accepted row transaction against the oldest expectation.
	always @(posedge clk) begin
		lcc_row_t got;
		if (arst_n && row.valid && row.ready) begin
			got.node_index = row.node_index;
			got.coefficient = row.coefficient;
			got.tri_count = row.tri_count;
			got.node_degree = row.node_degree;
			got.last_row = row.last_row;
			sb.check_row(got);
		end
	end

	// Offer one command and hold it until accepted; note it in the scoreboard then.
	// Valid stays up after the accept; the next call or drain() drops it.
	task automatic send_cmd(action_t act, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= act;
		cmd.src_node <= a;
		cmd.dst_node <= b;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		sb.note_command(act, a, b);
		commands_sent++;
	endtask

	task automatic add(int a, int b);
		send_cmd(ACT_ADD, IDX_W'(a), IDX_W'(b));
	endtask

	// Wait until all rows arrived, plus a margin for trailing work.
	task automatic drain();
		cmd.valid <= 1'b0;
		while (sb.pending_rows.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Build a random graph on the node window from base over span nodes, with occasional self-loops.
	task automatic random_graph(int n_edges, int base, int span);
		int a, b;
		for (int i = 0; i < n_edges; i++) begin
			a = base + $urandom_range(span - 1);
			b = ($urandom_range(9) == 0) ? a : base + $urandom_range(span - 1);
			add(a, b);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cycle_count = 0;
		commands_sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_cycles = 0;
		cmd.valid = 1'b0;
		cmd.action = ACT_NONE;
		cmd.src_node = '0;
		cmd.dst_node = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty compute, extremes, self-loop, repeated edge, unused action.
		send_cmd(ACT_COMPUTE, 6'h3f, 6'h2a);
		add(0, 63);
		add(63, 0);
		add(5, 5);
		add(0, 1);
		add(1, 63);
		add(0, 2);
		add(2, 1);
		send_cmd(ACT_NONE, 6'h15, 6'h2a);
		send_cmd(ACT_COMPUTE, 6'h15, 6'h2a);
		send_cmd(ACT_CLEAR, 6'h3f, 6'h3f);
		send_cmd(ACT_COMPUTE, '0, '0);
		// Full clique on four nodes: every coefficient is 1.0.
		for (int i = 40; i < 44; i++)
			for (int j = i + 1; j < 44; j++) add(i, j);
		add(42, 43);
		send_cmd(ACT_COMPUTE, 6'h2a, 6'h15);
		drain();

		// Random phases: each round clears, builds a random graph, computes, then offers more edges.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 62; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 62; end
				default: begin send_idle_pct = 31; stall_pct = 31; end
			endcase
			for (int g = 0; g < 3; g++) begin
				send_cmd(ACT_CLEAR, IDX_W'($urandom), IDX_W'($urandom));
				random_graph(10, $urandom_range(56), 8);
				if ($urandom_range(3) == 0)
					send_cmd(ACT_NONE, IDX_W'($urandom), IDX_W'($urandom));
				if (ph == 1 && g == 0) hold_off_cycles <= 3000;
				send_cmd(ACT_COMPUTE, IDX_W'($urandom), IDX_W'($urandom));
				// Keep offering edges while rows may be held back.
				random_graph(4, 0, 64);
			end
			drain();
		end
		// Larger graph across the full index range, once.
		send_idle_pct = 0;
		stall_pct = 0;
		send_cmd(ACT_CLEAR, '0, '0);
		random_graph(20, 0, 64);
		send_cmd(ACT_COMPUTE, '1, '1);
		drain();

		if (sb.errors == 0 && sb.pending_rows.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire
